// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prp, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prp) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cnd, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cnd)) else $error(msg);

`endif

// File: rtl/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg
// Types and constants of the fast stochastic %K block
// ----------------------------------------------------------------------------
`default_nettype none

package sfk_pkg;

	// price and register widths
	localparam int unsigned PRICE_BITS       = 32;
	localparam int unsigned KP_W             = 7;
	localparam logic [KP_W-1:0] KP_RESET     = 7'd5;
	localparam int unsigned WINDOW_DEPTH_DEF = 64;

	// apb port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_K_PERIOD   = 1'b0;

	// result scale: 100.0 in Q7.16
	localparam int unsigned FK_W            = 23;
	localparam logic [FK_W-1:0] FULL_SCALE  = 23'd6553600;
	localparam int unsigned QBIT_W          = 5;
	localparam logic [QBIT_W-1:0] QBIT_TOP  = 5'd22;

	typedef struct packed {
		logic [PRICE_BITS-1:0] bar_high;
		logic [PRICE_BITS-1:0] bar_low;
		logic [PRICE_BITS-1:0] bar_close;
	} bar_t;

	typedef struct packed {
		logic [FK_W-1:0] fast_k;
		logic            clamped;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_SETUP,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// File: rtl/stochastic_fast_k.sv
// ----------------------------------------------------------------------------
// stochastic_fast_k
// Fast stochastic %K over a sliding window of high/low bars
//
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------
// bar      | bar_valid / bar_ready  | bar_item (high, low, close Q16.16)
// result   | res_valid / res_ready  | res_item (fast_k Q7.16, clamped)
// config   | psel/penable/pwrite    | paddr, pwdata, prdata (k_period)
//
// During warm-up a bar passes only through the evaluate state. A result
// bar passes through evaluate, setup and finish, plus a window rescan
// when an extreme has left it (one stored entry read per cycle from the
// history memory) and a division when the close lies inside the range
// (one shared add/compare/subtract per step). bar_ready is high only
// between items. A finished result waits in the output register while
// the next bar is taken; the sequencer stalls at its last step only
// while that register is still full. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stochastic_fast_k
	import sfk_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               bar_valid,
	output logic                    bar_ready,
	input  wire bar_t               bar_item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output result_t                 res_item
);

	localparam int unsigned AGE_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned KC_W   = (AGE_W > KP_W) ? AGE_W : KP_W;
	localparam int unsigned PB     = PRICE_BITS;
	localparam logic [AGE_W-1:0]  AGE_EXPIRED = AGE_W'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [AGE_W:0]    DEPTH_WIDE  = (AGE_W + 1)'(WINDOW_DEPTH);

	state_t state_q, state_d;

	logic [KP_W-1:0]   kp_q;
	logic [SLOT_W-1:0] slot_q;
	logic [AGE_W-1:0]  seen_q;
	logic [AGE_W-1:0]  lo_age_q;
	logic [AGE_W-1:0]  hi_age_q;
	logic [AGE_W-1:0]  cmp_age_q;
	logic              need_lo_q;
	logic              need_hi_q;
	logic              res_valid_q;
	result_t           res_q;

	bar_t              bar_q;
	logic [PB-1:0]     lowest_q;
	logic [PB-1:0]     highest_q;
	logic [2*PB-1:0]   hist_mem_q [WINDOW_DEPTH];
	logic [2*PB-1:0]   rd_data_q;

	logic [PB-1:0]     num_q;
	logic [PB-1:0]     den_q;
	logic [PB-1:0]     rem_q;
	logic [FK_W-1:0]   quo_q;
	logic [QBIT_W-1:0] qbit_q;
	logic              phase_q;
	logic [FK_W-1:0]   fk_q;
	logic              flag_q;

	// control signals from the sequencer
	logic              bar_accept;
	logic              cfg_we;
	logic              warm;
	logic              lo_need;
	logic              hi_need;
	logic              scan_last;
	logic              div_last;
	logic              fin_fire;
	logic              do_div;

	logic [KC_W-1:0]   kp_wide;
	logic [AGE_W-1:0]  eff_k;
	logic [AGE_W-1:0]  eff_k_m1;
	logic [AGE_W-1:0]  rd_age;
	logic [AGE_W:0]    rd_wide;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] slot_next;
	logic [PB-1:0]     data_lo;
	logic [PB-1:0]     data_hi;

	logic              range_ok;
	logic              below;
	logic              at_top;

	logic [PB-1:0]     addend;
	logic [PB:0]       sum;
	logic [PB:0]       diff;
	logic              ge;
	logic [PB-1:0]     rem_next;
	logic [FK_W-1:0]   quo_next;
	logic              bit_set;

	// apb side
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_K_PERIOD);
	assign prdata = (paddr[2] == REG_K_PERIOD) ? PDATA_W'(kp_q) : '0;

	// effective window length, zero acts as one, capped at the depth
	assign kp_wide = KC_W'(kp_q);
	always_comb begin
		if (kp_q == '0) begin
			eff_k = AGE_W'(1);
		end else if (kp_wide > KC_W'(WINDOW_DEPTH)) begin
			eff_k = AGE_EXPIRED;
		end else begin
			eff_k = AGE_W'(kp_wide);
		end
	end
	assign eff_k_m1 = eff_k - AGE_W'(1);

	// history address of a given age, relative to the slot just written
	assign rd_age    = (state_q == ST_EVAL) ? eff_k_m1 : (cmp_age_q - AGE_W'(1));
	assign rd_wide   = (AGE_W + 1)'(slot_q) + DEPTH_WIDE - (AGE_W + 1)'(rd_age);
	assign rd_addr   = (rd_wide >= DEPTH_WIDE) ? SLOT_W'(rd_wide - DEPTH_WIDE)
		: SLOT_W'(rd_wide);
	assign slot_next = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
	assign data_lo   = rd_data_q[PB-1:0];
	assign data_hi   = rd_data_q[2*PB-1:PB];

	// range classification of the close
	assign range_ok = highest_q > lowest_q;
	assign below    = bar_q.bar_close < lowest_q;
	assign at_top   = bar_q.bar_close >= highest_q;

	// shared add, compare and subtract unit of the divider
	assign addend   = phase_q ? num_q : rem_q;
	assign sum      = {1'b0, rem_q} + {1'b0, addend};
	assign ge       = sum >= {1'b0, den_q};
	assign diff     = sum - {1'b0, den_q};
	assign rem_next = ge ? diff[PB-1:0] : sum[PB-1:0];
	assign quo_next = phase_q ? (quo_q + FK_W'(ge)) : {quo_q[FK_W-2:0], ge};
	assign bit_set  = FULL_SCALE[qbit_q];

	// sequencer outputs
	always_comb begin
		bar_ready = (state_q == ST_IDLE);
		warm      = (state_q == ST_EVAL) && (seen_q < eff_k);
		lo_need   = (lo_age_q >= eff_k);
		hi_need   = (hi_age_q >= eff_k);
		scan_last = (state_q == ST_SCAN) && (cmp_age_q == '0);
		do_div    = (state_q == ST_SETUP) && range_ok && !below && !at_top;
		div_last  = (state_q == ST_DIV) && (qbit_q == '0) && (phase_q || !bit_set);
		fin_fire  = (state_q == ST_FINISH) && (!res_valid_q || res_ready);
	end
	assign bar_accept = bar_valid && bar_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (bar_accept) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (warm) begin
					state_d = ST_IDLE;
				end else if (lo_need || hi_need) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_SETUP;
				end
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = do_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (fin_fire) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kp_q        <= KP_RESET;
			slot_q      <= '0;
			seen_q      <= '0;
			lo_age_q    <= AGE_EXPIRED;
			hi_age_q    <= AGE_EXPIRED;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// register write restarts the window
			if (cfg_we) begin
				kp_q     <= pwdata[KP_W-1:0];
				seen_q   <= '0;
				lo_age_q <= AGE_EXPIRED;
				hi_age_q <= AGE_EXPIRED;
			end
			// ages and warm-up count move on with each item
			if (bar_accept) begin
				if (lo_age_q < AGE_EXPIRED) lo_age_q <= lo_age_q + AGE_W'(1);
				if (hi_age_q < AGE_EXPIRED) hi_age_q <= hi_age_q + AGE_W'(1);
				if (seen_q < eff_k) seen_q <= seen_q + AGE_W'(1);
			end
			// new extreme taken directly
			if ((state_q == ST_EVAL) && !warm) begin
				if (!lo_need && (bar_q.bar_low <= lowest_q)) lo_age_q <= '0;
				if (!hi_need && (bar_q.bar_high >= highest_q)) hi_age_q <= '0;
			end
			// rescan, ties keep the older entry
			if (state_q == ST_SCAN) begin
				if (need_lo_q && ((cmp_age_q == eff_k_m1) || (data_lo < lowest_q))) begin
					lo_age_q <= cmp_age_q;
				end
				if (need_hi_q && ((cmp_age_q == eff_k_m1) || (data_hi > highest_q))) begin
					hi_age_q <= cmp_age_q;
				end
			end
			// write slot advances once the item is done
			if (warm || fin_fire) slot_q <= slot_next;
			// output register
			if (fin_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// history memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (bar_accept) hist_mem_q[slot_q] <= {bar_item.bar_high, bar_item.bar_low};
		rd_data_q <= hist_mem_q[rd_addr];
	end

	// window extremes and scan bookkeeping
	always_ff @(posedge clk) begin
		if (bar_accept) bar_q <= bar_item;
		if (state_q == ST_EVAL) begin
			need_lo_q <= lo_need;
			need_hi_q <= hi_need;
			cmp_age_q <= eff_k_m1;
			if (!warm) begin
				if (!lo_need && (bar_q.bar_low <= lowest_q)) lowest_q <= bar_q.bar_low;
				if (!hi_need && (bar_q.bar_high >= highest_q)) highest_q <= bar_q.bar_high;
			end
		end
		if (state_q == ST_SCAN) begin
			if (!scan_last) cmp_age_q <= cmp_age_q - AGE_W'(1);
			if (need_lo_q && ((cmp_age_q == eff_k_m1) || (data_lo < lowest_q))) begin
				lowest_q <= data_lo;
			end
			if (need_hi_q && ((cmp_age_q == eff_k_m1) || (data_hi > highest_q))) begin
				highest_q <= data_hi;
			end
		end
	end

	// divider sequencing and result value
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			num_q   <= bar_q.bar_close - lowest_q;
			den_q   <= highest_q - lowest_q;
			rem_q   <= '0;
			quo_q   <= '0;
			qbit_q  <= QBIT_TOP;
			phase_q <= 1'b0;
			if (!range_ok) begin
				fk_q   <= '0;
				flag_q <= 1'b0;
			end else if (below) begin
				fk_q   <= '0;
				flag_q <= 1'b1;
			end else if (at_top) begin
				fk_q   <= FULL_SCALE;
				flag_q <= (bar_q.bar_close != highest_q);
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (!phase_q && bit_set) begin
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				qbit_q  <= qbit_q - QBIT_W'(1);
			end
			if (div_last) begin
				fk_q   <= quo_next;
				flag_q <= 1'b0;
			end
		end
		if (fin_fire) begin
			res_q.fast_k  <= fk_q;
			res_q.clamped <= flag_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// checks
	`ASSERT_CLK(a_accept_starts_eval, (bar_valid && bar_ready) |=> (state_q == ST_EVAL), "accepted item did not start evaluation")
	`ASSERT_CLK(a_rem_below_den, (state_q == ST_DIV) |-> (rem_q < den_q), "division remainder reached divisor")
	`ASSERT_CLK(a_ages_in_window, (state_q == ST_SETUP) |-> (lo_age_q < eff_k && hi_age_q < eff_k), "window extreme age outside window")
	`ASSERT_CLK(a_clamp_ends, (res_valid_q && res_q.clamped) |-> (res_q.fast_k == '0 || res_q.fast_k == FULL_SCALE), "clamped result not at a scale end")
	`ASSERT_NEVER(a_res_range, res_valid_q && (res_q.fast_k > FULL_SCALE), "fast_k above full scale")

endmodule

`default_nettype wire
